[rtl/u2c_pkg.sv]
package u2c_pkg;

  localparam logic [15:0] MaxLenReset = 16'd512;
  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned TabSize = 61;

  localparam logic [10:0] CyrLo = 11'h410;
  localparam logic [10:0] CyrHi = 11'h44F;
  localparam logic [10:0] CyrOffset = 11'h350;
  localparam logic [10:0] LatLo = 11'h080;
  localparam logic [10:0] LatHi = 11'h0FF;
  localparam logic [10:0] DjeLo = 11'h402;
  localparam logic [10:0] DjeHi = 11'h403;
  localparam logic [10:0] DjeOffset = 11'h382;

  localparam logic [15:0] TabCp [0:TabSize-1] = '{
    16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h20AC, 16'h2030,
    16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F, 16'h0452, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h2122, 16'h0459,
    16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0, 16'h040E, 16'h045E,
    16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7, 16'h0401, 16'h00A9, 16'h0404,
    16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1, 16'h0406,
    16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116, 16'h0454,
    16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

  localparam logic [7:0] TabByte [0:TabSize-1] = '{
    8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
    8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h99, 8'h9A,
    8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0, 8'hA1, 8'hA2,
    8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA,
    8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB2,
    8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA,
    8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF
  };

  // one classified transaction waiting for the back end
  typedef struct packed {
    logic [10:0] cp;
    logic        has_char;
    logic        eos;
    logic        err;
  } rec_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } map_t;

  function automatic map_t map_code(input logic [10:0] cp);
    map_t r;
    logic [10:0] diff;
    r = '{ok: 1'b0, ch: 8'h00};
    diff = 11'h000;
    if (cp >= CyrLo && cp <= CyrHi) begin
      diff = cp - CyrOffset;
      r.ok = 1'b1;
      r.ch = diff[7:0];
    end else if (cp >= LatLo && cp <= LatHi) begin
      r.ok = 1'b1;
      r.ch = cp[7:0];
    end else if (cp >= DjeLo && cp <= DjeHi) begin
      diff = cp - DjeOffset;
      r.ok = 1'b1;
      r.ch = diff[7:0];
    end else begin
      for (int k = 0; k < TabSize; k++) begin
        if (TabCp[k] == {5'b00000, cp}) begin
          r.ok = 1'b1;
          r.ch = TabByte[k];
        end
      end
    end
    return r;
  endfunction

endpackage

[rtl/u2c_front.sv]
module u2c_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               last,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  output logic               rec_push,
  output u2c_pkg::rec_t      rec
);

  logic [15:0] max_len;
  logic [4:0]  lead_bits;
  logic [4:0]  lead_bits_next;
  logic        lead_pending;
  logic        lead_pending_next;
  logic        stopped;
  logic        stopped_next;
  logic [15:0] position;
  logic [15:0] position_next;

  logic [16:0]   pos_inc;
  logic          at_limit;
  logic [10:0]   lead_cp;
  u2c_pkg::map_t lead_map;

  assign pos_inc  = {1'b0, position} + 17'd1;
  assign at_limit = pos_inc >= {1'b0, max_len};
  assign lead_cp  = {lead_bits, in_byte[5:0]};
  assign lead_map = u2c_pkg::map_code(lead_cp);

  always_comb begin
    rec_push          = 1'b0;
    rec               = '0;
    lead_bits_next    = lead_bits;
    lead_pending_next = lead_pending;
    stopped_next      = stopped;
    position_next     = position;
    if (accept) begin
      if (stopped) begin
        if (last) begin
          stopped_next = 1'b0;
          position_next = 16'd0;
        end
      end else begin
        position_next = pos_inc[15:0];
        if (lead_pending) begin
          lead_pending_next = 1'b0;
          lead_bits_next = 5'd0;
          rec_push = 1'b1;
          if (in_byte == 8'h00 || !lead_map.ok) begin
            rec.eos = 1'b1;
            rec.err = 1'b1;
          end else begin
            rec.cp = lead_cp;
            rec.has_char = 1'b1;
            rec.eos = last || at_limit;
          end
        end else if ({1'b0, position} >= {1'b0, max_len}) begin
          rec_push = 1'b1;
          rec.eos = 1'b1;
        end else if (in_byte == 8'h00) begin
          rec_push = 1'b1;
          rec.eos = 1'b1;
        end else if (!in_byte[7]) begin
          rec_push = 1'b1;
          rec.cp = {3'b000, in_byte};
          rec.has_char = 1'b1;
          rec.eos = last || at_limit;
        end else if (!in_byte[5]) begin
          if (last) begin
            // lead byte with nothing to follow it
            rec_push = 1'b1;
            rec.eos = 1'b1;
            rec.err = 1'b1;
          end else begin
            lead_bits_next = in_byte[4:0];
            lead_pending_next = 1'b1;
          end
        end else begin
          rec_push = 1'b1;
          rec.eos = 1'b1;
          rec.err = 1'b1;
        end
        if (rec_push && rec.eos) begin
          lead_pending_next = 1'b0;
          lead_bits_next = 5'd0;
          if (last) begin
            stopped_next = 1'b0;
            position_next = 16'd0;
          end else begin
            stopped_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= u2c_pkg::MaxLenReset;
      lead_bits    <= 5'd0;
      lead_pending <= 1'b0;
      stopped      <= 1'b0;
      position     <= 16'd0;
    end else begin
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      lead_bits    <= lead_bits_next;
      lead_pending <= lead_pending_next;
      stopped      <= stopped_next;
      position     <= position_next;
    end
  end

endmodule

[rtl/u2c_queue.sv]
module u2c_queue #(
  parameter int unsigned Depth = u2c_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u2c_pkg::rec_t wr_rec,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output u2c_pkg::rec_t rd_rec
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u2c_pkg::rec_t entries [0:Depth-1];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = count == FullCnt;
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/u2c_back.sv]
module u2c_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  u2c_pkg::rec_t q_rec,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          has_char,
  output logic          end_of_string,
  output logic          error
);

  logic          out_valid;
  logic          load;
  u2c_pkg::map_t mapped;
  logic [7:0]    ch;

  assign mapped = u2c_pkg::map_code(q_rec.cp);
  // ascii bytes pass through, everything else comes from the mapping
  assign ch     = (q_rec.cp[10:7] == 4'd0) ? q_rec.cp[7:0] : mapped.ch;
  assign load   = !q_empty && (!out_valid || pop);
  assign q_pop  = load;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= q_rec.has_char ? ch : 8'h00;
      has_char      <= q_rec.has_char;
      end_of_string <= q_rec.eos;
      error         <= q_rec.err;
    end
  end

endmodule

[rtl/utf8_to_cp1251_converter_unit.sv]
// UTF-8 to Windows-1251 byte converter. Takes one UTF-8 byte per cycle while
// full is low and delivers at most one Windows-1251 byte per input byte, in
// order; a lead byte of a two-byte sequence gives no transaction of its own.
// Sustained rate is one byte per cycle on both sides while pop stays high.
// A result is written into the classification queue, then into the output
// register. The front end keeps the string state (pending lead, position,
// stop after an error or end) and checks that a code point maps; the back end
// forms the output byte. full rises once the queue of QueueDepth entries and
// the output register have filled while pop is low. The user must write
// max_len through cfg_write/cfg_data only while idle; the block never checks.
module utf8_to_cp1251_converter_unit #(
  parameter int unsigned QueueDepth = u2c_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        has_char,
  output logic        end_of_string,
  output logic        error,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  logic          accept;
  logic          rec_push;
  u2c_pkg::rec_t rec;
  logic          q_empty;
  logic          q_pop;
  u2c_pkg::rec_t q_rec;

  assign accept = push && !full;

  u2c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  u2c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wr_rec (rec),
    .full   (full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_rec (q_rec)
  );

  u2c_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rec         (q_rec),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .has_char      (has_char),
    .end_of_string (end_of_string),
    .error         (error)
  );

endmodule

[rtl/u2c_checker.sv]
module u2c_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       has_char,
  input logic       end_of_string,
  input logic       error
);

  // nothing left over from before reset
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not empty after reset");

  // a failed conversion always closes the string
  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    !empty && error |-> end_of_string)
    else $error("error without end_of_string");

  a_err_no_char: assert property (@(posedge clk) disable iff (rst)
    !empty && error |-> !has_char)
    else $error("error transaction carries a character");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !has_char |-> out_byte == 8'h00)
    else $error("out_byte not zero without a character");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(end_of_string))
    else $error("waiting transaction changed");

endmodule

bind utf8_to_cp1251_converter_unit u2c_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_byte      (out_byte),
  .has_char      (has_char),
  .end_of_string (end_of_string),
  .error         (error)
);

[bench/testbench.sv]
module testbench;

  localparam int DirectedCount = 25;
  localparam int LimitCycles = 400000;
  localparam int LongHold = 300;
  localparam int SettleCycles = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_char;
    logic       eos;
    logic       err;
  } cp1251_char_t;

  // typed = the expectation is written in the row; yields = that row gives a transaction
  typedef struct packed {
    logic [7:0]   in_b;
    logic         in_last;
    logic         typed;
    logic         yields;
    cp1251_char_t want;
  } step_row_t;

  localparam step_row_t DirectedSteps [DirectedCount] = '{
    {8'h41, 1'b0, 1'b1, 1'b1, 8'h41, 1'b1, 1'b0, 1'b0},
    {8'h7F, 1'b0, 1'b1, 1'b1, 8'h7F, 1'b1, 1'b0, 1'b0},
    {8'hD0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h90, 1'b0, 1'b1, 1'b1, 8'hC0, 1'b1, 1'b0, 1'b0},
    {8'hD1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h8F, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0},
    {8'hC2, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hE2, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    {8'h41, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h42, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hC1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h81, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    {8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hD0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    {8'h55, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hD0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    {8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
    {8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hD1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h93, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hD0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h82, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h7F, 1'b1, 1'b1, 1'b1, 8'h7F, 1'b1, 1'b1, 1'b0}
  };

  localparam int PhaseCount = 7;
  localparam logic [15:0] PhaseMaxLen [PhaseCount] = '{
    16'd1, 16'd65535, 16'd2, 16'd3, 16'd40, 16'd65535, 16'd7
  };

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        last;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        has_char;
  logic        end_of_string;
  logic        error;
  logic        cfg_write;
  logic [15:0] cfg_data;

  utf8_to_cp1251_converter_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .last(last),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .has_char(has_char),
    .end_of_string(end_of_string),
    .error(error),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  cp1251_char_t pending_chars [$];
  logic [8:0]   utf8_seq [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           live_items = 0;
  bit           gaps_on = 1'b1;
  bit           long_hold_req = 1'b0;

  // converter state as the block should hold it
  logic [15:0] limit_len;
  logic [4:0]  lead_low;
  logic        lead_held;
  logic        dropping;
  logic [15:0] byte_pos;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    if (mismatch_count < 50) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic void add_expected(input cp1251_char_t c);
    pending_chars.insert(pending_chars.size(), c);
  endfunction

  function automatic void add_seq_byte(input logic [8:0] v);
    utf8_seq.insert(utf8_seq.size(), v);
  endfunction

  function automatic logic [8:0] to_cp1251(input logic [10:0] cp);
    logic [8:0]  hit;
    logic [10:0] diff;
    hit = 9'h000;
    if (cp >= u2c_pkg::CyrLo && cp <= u2c_pkg::CyrHi) begin
      diff = cp - u2c_pkg::CyrOffset;
      hit = {1'b1, diff[7:0]};
    end else if (cp >= u2c_pkg::LatLo && cp <= u2c_pkg::LatHi) begin
      hit = {1'b1, cp[7:0]};
    end else if (cp >= u2c_pkg::DjeLo && cp <= u2c_pkg::DjeHi) begin
      diff = cp - u2c_pkg::DjeOffset;
      hit = {1'b1, diff[7:0]};
    end else begin
      for (int k = 0; k < u2c_pkg::TabSize; k++) begin
        if (u2c_pkg::TabCp[k] == {5'b00000, cp}) hit = {1'b1, u2c_pkg::TabByte[k]};
      end
    end
    return hit;
  endfunction

  function automatic void clear_string_state();
    lead_low = '0;
    lead_held = 1'b0;
    dropping = 1'b0;
    byte_pos = '0;
  endfunction

  task automatic convert_utf8_byte(input logic [7:0] b, input logic l,
                                   output logic gives, output cp1251_char_t res);
    logic [16:0] next_pos;
    logic [15:0] old_pos;
    logic        at_limit;
    logic [8:0]  hit;
    gives = 1'b0;
    res = '0;
    if (dropping) begin
      if (l) clear_string_state();
    end else begin
      old_pos = byte_pos;
      next_pos = {1'b0, old_pos} + 17'd1;
      byte_pos = next_pos[15:0];
      at_limit = next_pos >= {1'b0, limit_len};
      gives = 1'b1;
      if (lead_held) begin
        lead_held = 1'b0;
        hit = to_cp1251({lead_low, b[5:0]});
        lead_low = '0;
        if (b == 8'h00 || !hit[8]) res = '{8'h00, 1'b0, 1'b1, 1'b1};
        else res = '{hit[7:0], 1'b1, l || at_limit, 1'b0};
      end else if (old_pos >= limit_len || b == 8'h00) begin
        res = '{8'h00, 1'b0, 1'b1, 1'b0};
      end else if (!b[7]) begin
        res = '{b, 1'b1, l || at_limit, 1'b0};
      end else if (b[5] || l) begin
        // bad lead, or a lead that can never get its second byte
        res = '{8'h00, 1'b0, 1'b1, 1'b1};
      end else begin
        lead_low = b[4:0];
        lead_held = 1'b1;
        gives = 1'b0;
      end
      if (gives && res.eos) begin
        if (l) clear_string_state();
        else begin
          dropping = 1'b1;
          lead_held = 1'b0;
          lead_low = '0;
        end
      end
    end
  endtask

  // one input transaction, with an optional idle burst in front of it
  task automatic offer_byte(input logic [7:0] b, input logic l,
                            output logic gives, output cp1251_char_t res);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    last <= l;
    do @(posedge clk); while (full);
    if (!dropping) live_items++;
    convert_utf8_byte(b, l, gives, res);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic l);
    logic         gives;
    cp1251_char_t res;
    offer_byte(b, l, gives, res);
    if (gives) add_expected(res);
  endtask

  function automatic void append_cp(input logic [10:0] cp);
    add_seq_byte({1'b0, 3'b110, cp[10:6]});
    add_seq_byte({1'b0, 2'b10, cp[5:0]});
  endfunction

  task automatic send_random_string();
    int         nchars;
    int         pick;
    int         k;
    logic [8:0] item;
    utf8_seq.delete();
    nchars = $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) begin
      // noise
      repeat (nchars) add_seq_byte({$urandom_range(0, 3) == 0, 8'($urandom)});
    end else begin
      repeat (nchars) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          add_seq_byte({1'b0, 8'($urandom_range(1, 8'h7F))});
        end else if (pick < 65) begin
          append_cp(11'($urandom_range(u2c_pkg::CyrLo, u2c_pkg::CyrHi)));
        end else if (pick < 73) begin
          append_cp(11'($urandom_range(u2c_pkg::LatLo, u2c_pkg::LatHi)));
        end else if (pick < 78) begin
          append_cp(11'($urandom_range(u2c_pkg::DjeLo, u2c_pkg::DjeHi)));
        end else if (pick < 86) begin
          do k = $urandom_range(0, u2c_pkg::TabSize - 1);
          while (u2c_pkg::TabCp[k] >= 16'h0800);
          append_cp(u2c_pkg::TabCp[k][10:0]);
        end else if (pick < 93) begin
          // any two-byte form: overlong and unmapped code points too
          append_cp(11'($urandom));
        end else if (pick < 96) begin
          add_seq_byte({1'b0, 3'b111, 5'($urandom)});
        end else begin
          // raw byte, stray continuations and lone leads among them
          add_seq_byte({1'b0, 8'($urandom_range(8'h80, 8'hFF))});
        end
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        utf8_seq[utf8_seq.size() - 1][8] = 1'b1;
      end else if (pick < 8) begin
        add_seq_byte({1'($urandom), 8'h00});
      end else begin
        add_seq_byte({1'b0, 8'h00});
        add_seq_byte({1'b1, 8'($urandom_range(1, 8'h7F))});
      end
    end
    foreach (utf8_seq[i]) begin
      item = utf8_seq[i];
      feed_byte(item[7:0], item[8]);
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = live_items;
    while (live_items - start < target) send_random_string();
    // leave a string open so the next limit can land below its position
    repeat (5) feed_byte(8'($urandom_range(1, 8'h7F)), 1'b0);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    limit_len = value;
  endtask

  // receiver: random pop bursts, plus one long hold-off per request
  always begin
    @(posedge clk);
    if (rst) begin
      pop <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      pop <= 1'b0;
      repeat (LongHold) @(posedge clk);
      pop <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      pop <= 1'b1;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    cp1251_char_t want;
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction out_byte=%h", out_byte));
      end else begin
        want = pending_chars.pop_front();
        if (out_byte !== want.out_byte)
          note_mismatch($sformatf("out_byte %h, want %h", out_byte, want.out_byte));
        if (has_char !== want.has_char)
          note_mismatch($sformatf("has_char %b, want %b", has_char, want.has_char));
        if (end_of_string !== want.eos)
          note_mismatch($sformatf("end_of_string %b, want %b", end_of_string, want.eos));
        if (error !== want.err)
          note_mismatch($sformatf("error %b, want %b", error, want.err));
      end
    end
  end

  initial begin
    logic         gives;
    cp1251_char_t res;
    step_row_t    row;
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    in_byte = 8'h00;
    last = 1'b0;
    pop = 1'b0;
    cfg_write = 1'b0;
    cfg_data = 16'h0000;
    limit_len = u2c_pkg::MaxLenReset;
    clear_string_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirectedCount; i++) begin
      row = DirectedSteps[i];
      offer_byte(row.in_b, row.in_last, gives, res);
      if (row.typed) begin
        if (row.yields) add_expected(row.want);
      end else if (gives) begin
        add_expected(res);
      end
    end
    run_random(90);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      write_max_len(PhaseMaxLen[p]);
      if (p == 1 || p == 4) long_hold_req = 1'b1;
      run_random(90);
    end

    drain_results();
    write_max_len(16'($urandom_range(1, 64)));
    run_random(80);

    // closing stretch at full rate on both sides
    drain_results();
    gaps_on = 1'b0;
    write_max_len(u2c_pkg::MaxLenReset);
    run_random(120);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
